// ===== rtl/core/bpgm_pkg.sv =====
package bpgm_pkg;

	// field widths
	localparam int KIND_W    = 2;
	localparam int BYTE_W    = 8;
	localparam int MASK_W    = 32;
	localparam int CFG_IDX_W = 2;

	// class table geometry
	localparam int TABLE_DEPTH = 256;

	// position vector
	localparam int POSITIONS_DEF = 32;
	localparam int VEC_MAX       = 64;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TEXT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STAR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DSTAR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT  = 2'd2;

	// path separator byte
	localparam logic [BYTE_W-1:0] SLASH_BYTE = 8'h2f;

	// register reset values
	localparam logic [MASK_W-1:0] ACCEPT_RST = 32'h0000_0001;

endpackage

// ===== rtl/core/bpgm_ram.sv =====
module bpgm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/bitparallel_glob_matcher_unit.sv =====
// Shift-and glob matcher. Load words fill the 256-entry class table, text words
// advance the live-position vector, and an end word returns one matched word and
// restarts the vector. One input word is taken every clock: the class table read
// for a text byte is issued in the accept cycle and the vector update runs in the
// next; an end word reaches the output word register by way of stage 1.
// The input stalls only while an end word waits behind an output word that is
// itself stalled. The table reads as all zeros after reset through per-entry
// valid bits, so no clearing pass is needed. Configuration writes take effect on
// the next clock and are to be made only while the block is idle.
module bitparallel_glob_matcher_unit #(
	parameter int POSITIONS = bpgm_pkg::POSITIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [bpgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpgm_pkg::MASK_W-1:0]    cfg_wdata,
	// input words
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bpgm_pkg::KIND_W-1:0]    kind,
	input  logic [bpgm_pkg::BYTE_W-1:0]    entry_index,
	input  logic [bpgm_pkg::MASK_W-1:0]    entry_mask,
	input  logic [bpgm_pkg::BYTE_W-1:0]    text_byte,
	// result words
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           matched
);

	import bpgm_pkg::*;

	localparam logic [POSITIONS-1:0] VEC_ONE = POSITIONS'(1);

	logic [MASK_W-1:0]      star_q;
	logic [MASK_W-1:0]      dstar_q;
	logic [MASK_W-1:0]      accept_q;
	logic [TABLE_DEPTH-1:0] tbl_vld_q;
	logic [POSITIONS-1:0]   vec_q;

	logic                   item_vld_s1;
	logic [KIND_W-1:0]      kind_s1;
	logic [BYTE_W-1:0]      byte_s1;
	logic                   hit_vld_s1;

	logic                   out_vld_q;
	logic                   matched_q;

	logic                   in_acc;
	logic                   adv;
	logic                   end_s1;
	logic                   text_s1;
	logic                   end_go;
	logic                   tbl_we;
	logic                   tbl_re;
	logic [MASK_W-1:0]      tbl_rdata;

	logic [VEC_MAX-1:0]     star_ext;
	logic [VEC_MAX-1:0]     dstar_ext;
	logic [VEC_MAX-1:0]     accept_ext;
	logic [VEC_MAX-1:0]     cls_ext;
	logic [POSITIONS-1:0]   star_v;
	logic [POSITIONS-1:0]   dstar_v;
	logic [POSITIONS-1:0]   accept_v;
	logic [POSITIONS-1:0]   cls_v;
	logic [POSITIONS-1:0]   keep_v;
	logic [POSITIONS-1:0]   vec_nxt;

	// handshake and pipeline advance
	assign end_s1   = item_vld_s1 && (kind_s1 == KIND_END);
	assign text_s1  = item_vld_s1 && (kind_s1 == KIND_TEXT);
	assign adv      = !end_s1 || !out_vld_q || !out_stall;
	assign in_stall = !adv;
	assign in_acc   = in_valid && !in_stall;
	assign end_go   = end_s1 && adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			star_q   <= '0;
			dstar_q  <= '0;
			accept_q <= ACCEPT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_STAR:   star_q   <= cfg_wdata;
				REG_DSTAR:  dstar_q  <= cfg_wdata;
				REG_ACCEPT: accept_q <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	// class table: write on load, read ahead on text
	assign tbl_we = in_acc && (kind == KIND_LOAD);
	assign tbl_re = in_acc && (kind == KIND_TEXT);

	bpgm_ram #(
		.WIDTH (MASK_W),
		.DEPTH (TABLE_DEPTH)
	) u_class_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (entry_index),
		.wdata (entry_mask),
		.re    (tbl_re),
		.raddr (text_byte),
		.rdata (tbl_rdata)
	);

	// per-entry valid bits stand in for a cleared table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (tbl_we) begin
			tbl_vld_q[entry_index] <= 1'b1;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (adv) begin
			item_vld_s1 <= in_acc;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1    <= kind;
			byte_s1    <= text_byte;
			hit_vld_s1 <= tbl_vld_q[text_byte];
		end
	end

	// masks fitted to the vector width
	assign star_ext   = VEC_MAX'(star_q);
	assign dstar_ext  = VEC_MAX'(dstar_q);
	assign accept_ext = VEC_MAX'(accept_q);
	assign cls_ext    = hit_vld_s1 ? VEC_MAX'(tbl_rdata) : '0;
	assign star_v     = star_ext[POSITIONS-1:0];
	assign dstar_v    = dstar_ext[POSITIONS-1:0];
	assign accept_v   = accept_ext[POSITIONS-1:0];
	assign cls_v      = cls_ext[POSITIONS-1:0];

	// shift-and update, single stars stop at slash
	always_comb begin
		keep_v = vec_q & dstar_v;
		if (byte_s1 != SLASH_BYTE) begin
			keep_v = keep_v | (vec_q & star_v);
		end
		vec_nxt = ((vec_q & cls_v) << 1) | keep_v;
	end

	// live-position vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_q <= VEC_ONE;
		end else if (end_go) begin
			vec_q <= VEC_ONE;
		end else if (text_s1) begin
			vec_q <= vec_nxt;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (end_go) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_go) begin
			matched_q <= |(vec_q & accept_v);
		end
	end

	assign out_valid = out_vld_q;
	assign matched   = matched_q;

	// input stalls only behind a blocked end word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (end_s1 && out_vld_q && out_stall))
		else $error("input stalled without a blocked end word");

	// an end word restarts the vector
	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		end_go |=> (vec_q == VEC_ONE))
		else $error("vector not restarted after end word");

	// a new output word comes only from an end word
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !$past(out_vld_q)) |-> $past(end_s1))
		else $error("output word without an end word");

	// a stalled output word must not be overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_stall) |=> (out_vld_q && $stable(matched_q)))
		else $error("stalled output word lost");

endmodule
